FILE: rtl/utf8d_pkg.sv
// utf8d_pkg: types, constants and queue sizes for the utf-8 decoder
// no dependencies; every rtl module of the decoder imports it

package utf8d_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_DEPTH   = 2;
  localparam int OPTR_W      = $clog2(OUT_DEPTH);
  localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);
  localparam int CP_W        = 21;

  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD2_LO    = 8'hc2;
  localparam logic [7:0] LEAD2_HI    = 8'hdf;
  localparam logic [7:0] LEAD3_LO    = 8'he0;
  localparam logic [7:0] LEAD3_HI    = 8'hef;
  localparam logic [7:0] LEAD4_LO    = 8'hf0;
  localparam logic [7:0] LEAD4_HI    = 8'hf4;
  localparam logic [7:0] CONT_LO     = 8'h80;
  localparam logic [7:0] STRICT_LO   = 8'ha0;
  localparam logic [7:0] CONT_HI     = 8'hbf;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            code_present;
    logic            stream_end;
  } result_t;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD3_E0,
    CLS_LEAD4,
    CLS_IGNORE
  } byte_class_t;

  typedef struct packed {
    byte_class_t cls;
    logic        cont_ok;
    logic        cont_strict_ok;
    logic [7:0]  data_byte;
    logic        last;
  } class_item_t;

endpackage

FILE: rtl/utf8d_front.sv
// utf8d_front: classifies each incoming byte as ascii, lead or other
// depends on utf8d_pkg

module utf8d_front (
  input  utf8d_pkg::in_item_t    item,
  output utf8d_pkg::class_item_t cls_item
);
  import utf8d_pkg::*;

  logic [7:0] b;

  assign b = item.data_byte;

  always_comb begin
    cls_item.data_byte      = b;
    cls_item.last           = item.final_byte;
    cls_item.cont_ok        = (b >= CONT_LO) && (b <= CONT_HI);
    cls_item.cont_strict_ok = (b >= STRICT_LO) && (b <= CONT_HI);
    if (b < ASCII_LIMIT) begin
      cls_item.cls = CLS_ASCII;
    end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
      cls_item.cls = CLS_LEAD2;
    end else if (b == LEAD3_LO) begin
      cls_item.cls = CLS_LEAD3_E0;
    end else if (b > LEAD3_LO && b <= LEAD3_HI) begin
      cls_item.cls = CLS_LEAD3;
    end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
      cls_item.cls = CLS_LEAD4;
    end else begin
      cls_item.cls = CLS_IGNORE;
    end
  end

endmodule

FILE: rtl/utf8d_queue.sv
// utf8d_queue: short queue of classified bytes between front and back
// depends on utf8d_pkg

module utf8d_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  utf8d_pkg::class_item_t wr_item,
  output logic                   full,
  input  logic                   rd_en,
  output utf8d_pkg::class_item_t rd_item,
  output logic                   empty
);
  import utf8d_pkg::*;

  class_item_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    do_wr && !do_rd |=> count == $past(count) + 1'b1)
    else $error("queue count missed a write");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    do_rd && !do_wr |=> count == $past(count) - 1'b1)
    else $error("queue count missed a read");

endmodule

FILE: rtl/utf8d_back.sv
// utf8d_back: sequence state, code point assembly and result buffer
// depends on utf8d_pkg

module utf8d_back (
  input  logic                   clk,
  input  logic                   rst,
  input  utf8d_pkg::class_item_t cls_item,
  input  logic                   item_valid,
  output logic                   take,
  output utf8d_pkg::result_t     result,
  output logic                   empty,
  input  logic                   pop
);
  import utf8d_pkg::*;

  logic [1:0]        bytes_pending;
  logic [CP_W-1:0]   partial_value;
  logic              strict_second;
  logic              sequence_good;
  logic [1:0]        bytes_pending_next;
  logic [CP_W-1:0]   partial_value_next;
  logic              strict_second_next;
  logic              sequence_good_next;

  result_t           res_buf [OUT_DEPTH];
  logic [OPTR_W-1:0] ob_wr;
  logic [OPTR_W-1:0] ob_rd;
  logic [OCNT_W-1:0] ob_count;

  logic              have;
  logic [CP_W-1:0]   cp;
  logic              bad;
  logic              good_after;
  logic [CP_W-1:0]   shifted;
  logic              emit;
  logic              do_pop;
  logic              do_push;
  logic [7:0]        b;

  assign b       = cls_item.data_byte;
  assign take    = item_valid && (ob_count != OCNT_W'(OUT_DEPTH));
  assign empty   = (ob_count == '0);
  assign do_pop  = pop && !empty;
  assign emit    = have || cls_item.last;
  assign do_push = take && emit;
  assign result  = res_buf[ob_rd];

  assign bad        = strict_second ? !cls_item.cont_strict_ok : !cls_item.cont_ok;
  assign good_after = sequence_good && !bad;
  assign shifted    = {partial_value[CP_W-7:0], b[5:0]};

  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_value_next = partial_value;
    strict_second_next = strict_second;
    sequence_good_next = sequence_good;
    have               = 1'b0;
    cp                 = '0;
    if (bytes_pending != 2'd0) begin
      bytes_pending_next = bytes_pending - 2'd1;
      partial_value_next = shifted;
      strict_second_next = 1'b0;
      sequence_good_next = good_after;
      if (bytes_pending == 2'd1) begin
        have               = good_after;
        cp                 = good_after ? shifted : '0;
        partial_value_next = '0;
        sequence_good_next = 1'b1;
      end
    end else begin
      case (cls_item.cls)
        CLS_ASCII: begin
          have = 1'b1;
          cp   = CP_W'(b[6:0]);
        end
        CLS_LEAD2: begin
          bytes_pending_next = 2'd1;
          partial_value_next = CP_W'(b[4:0]);
          sequence_good_next = 1'b1;
        end
        CLS_LEAD3: begin
          bytes_pending_next = 2'd2;
          partial_value_next = CP_W'(b[3:0]);
          strict_second_next = 1'b0;
          sequence_good_next = 1'b1;
        end
        CLS_LEAD3_E0: begin
          bytes_pending_next = 2'd2;
          partial_value_next = CP_W'(b[3:0]);
          strict_second_next = 1'b1;
          sequence_good_next = 1'b1;
        end
        CLS_LEAD4: begin
          bytes_pending_next = 2'd3;
          partial_value_next = CP_W'(b[2:0]);
          sequence_good_next = 1'b1;
        end
        CLS_IGNORE: begin
        end
        default: begin
        end
      endcase
    end
    if (cls_item.last) begin
      bytes_pending_next = 2'd0;
      partial_value_next = '0;
      strict_second_next = 1'b0;
      sequence_good_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      partial_value <= '0;
      strict_second <= 1'b0;
      sequence_good <= 1'b1;
    end else if (take) begin
      bytes_pending <= bytes_pending_next;
      partial_value <= partial_value_next;
      strict_second <= strict_second_next;
      sequence_good <= sequence_good_next;
    end
  end

  // result buffer, two entries so a stalled reader does not block the next byte
  always_ff @(posedge clk) begin
    if (do_push) begin
      res_buf[ob_wr] <= '{code_point: cp, code_present: have, stream_end: cls_item.last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wr    <= '0;
      ob_rd    <= '0;
      ob_count <= '0;
    end else begin
      if (do_push) begin
        ob_wr <= (ob_wr == OPTR_W'(OUT_DEPTH - 1)) ? '0 : ob_wr + 1'b1;
      end
      if (do_pop) begin
        ob_rd <= (ob_rd == OPTR_W'(OUT_DEPTH - 1)) ? '0 : ob_rd + 1'b1;
      end
      if (do_push && !do_pop) begin
        ob_count <= ob_count + 1'b1;
      end else if (do_pop && !do_push) begin
        ob_count <= ob_count - 1'b1;
      end
    end
  end

  a_ob_range: assert property (@(posedge clk) disable iff (rst)
    ob_count <= OCNT_W'(OUT_DEPTH))
    else $error("result buffer count above depth");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    take && cls_item.last |=> bytes_pending == 2'd0 && sequence_good && !strict_second)
    else $error("sequence state not cleared after last byte");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> ob_count == $past(ob_count) + 1'b1)
    else $error("result buffer missed a transfer");

  a_strict_only_second: assert property (@(posedge clk) disable iff (rst)
    strict_second |-> bytes_pending == 2'd2)
    else $error("strict check armed outside second byte");

endmodule

FILE: rtl/utf8_to_code_point_decoder.sv
// utf8_to_code_point_decoder: top level of the utf-8 byte stream decoder
// depends on utf8d_pkg, utf8d_front, utf8d_queue and utf8d_back
//
// usage:
//   input channel: item carries one byte and its final mark; a transfer
//   happens on a rising edge with push high and full low
//   result channel: result holds the oldest waiting result while empty is
//   low; a transfer happens on a rising edge with pop high and empty low
//   each byte yields at most one result: a completed code point, or an end
//   mark on the final byte (with or without a code point)
//   a byte is written into the queue, then taken by the back end, which
//   writes its result into the result buffer, from which it can be popped
//   throughput: one byte per cycle while neither buffer is full, set by the
//   sequence state update in the back end
//   a four-entry queue sits between the classifier and the back end, and a
//   two-entry result buffer sits at the output, so a stalled receiver first
//   fills the result buffer, then the queue, and only then raises full
//   reset (rst, synchronous) empties both buffers and closes any open
//   sequence

module utf8_to_code_point_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  utf8d_pkg::in_item_t item,
  output logic                full,
  output utf8d_pkg::result_t  result,
  output logic                empty,
  input  logic                pop
);
  import utf8d_pkg::*;

  class_item_t front_item;
  class_item_t back_item;
  logic        q_empty;
  logic        take;

  utf8d_front u_front (
    .item     (item),
    .cls_item (front_item)
  );

  utf8d_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_item (front_item),
    .full    (full),
    .rd_en   (take),
    .rd_item (back_item),
    .empty   (q_empty)
  );

  utf8d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cls_item   (back_item),
    .item_valid (!q_empty),
    .take       (take),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

FILE: bench/utf8_to_code_point_decoder_check.sv
`timescale 1ns / 100ps
// utf8_to_code_point_decoder_check: watches both channels of the decoder,
// predicts each result from the accepted bytes and compares field by field
// depends on utf8d_pkg for the item and result types and byte constants

module utf8_to_code_point_decoder_check (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  utf8d_pkg::in_item_t item,
  input  logic                full,
  input  utf8d_pkg::result_t  result,
  input  logic                empty,
  input  logic                pop,
  output int                  fail_count,
  output int                  outstanding,
  output int                  points_seen,
  output int                  ends_seen
);
  import utf8d_pkg::*;

  logic [1:0]      seq_left;
  logic [CP_W-1:0] seq_value;
  logic            seq_strict;
  logic            seq_good;

  result_t expected_q[$];
  result_t want;
  result_t predicted;
  int      fails  = 0;
  int      points = 0;
  int      ends   = 0;

  function automatic void close_sequence();
    seq_left   = '0;
    seq_value  = '0;
    seq_strict = 1'b0;
    seq_good   = 1'b1;
  endfunction

  function automatic bit decode_utf8_byte(input in_item_t it, output result_t res);
    logic [7:0] b;
    logic [7:0] lo;
    bit         done;
    b    = it.data_byte;
    done = 1'b0;
    res  = '0;
    if (seq_left != 0) begin
      lo = seq_strict ? STRICT_LO : CONT_LO;
      if (b < lo || b > CONT_HI) seq_good = 1'b0;
      seq_strict = 1'b0;
      seq_value  = {seq_value[CP_W-7:0], b[5:0]};
      seq_left   = seq_left - 2'd1;
      if (seq_left == 0) begin
        if (seq_good) begin
          done           = 1'b1;
          res.code_point = seq_value;
        end
        close_sequence();
      end
    end else if (b < ASCII_LIMIT) begin
      done           = 1'b1;
      res.code_point = CP_W'(b);
    end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
      seq_left  = 2'd1;
      seq_value = CP_W'(b[4:0]);
      seq_good  = 1'b1;
    end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
      seq_left   = 2'd2;
      seq_value  = CP_W'(b[3:0]);
      seq_strict = (b == LEAD3_LO);
      seq_good   = 1'b1;
    end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
      seq_left  = 2'd3;
      seq_value = CP_W'(b[2:0]);
      seq_good  = 1'b1;
    end
    if (it.final_byte) close_sequence();
    res.code_present = done;
    res.stream_end   = it.final_byte;
    return done || it.final_byte;
  endfunction

  initial close_sequence();

  always @(posedge clk) begin
    if (rst) begin
      close_sequence();
      expected_q.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: code_point %h, code_present %b, stream_end %b",
                 result.code_point, result.code_present, result.stream_end);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (result.code_point !== want.code_point) begin
            $error("code_point: expected %h, actual %h", want.code_point, result.code_point);
            fails++;
          end
          if (result.code_present !== want.code_present) begin
            $error("code_present: expected %b, actual %b",
                   want.code_present, result.code_present);
            fails++;
          end
          if (result.stream_end !== want.stream_end) begin
            $error("stream_end: expected %b, actual %b", want.stream_end, result.stream_end);
            fails++;
          end
          if (want.code_present) points++;
          if (want.stream_end) ends++;
        end
      end
      if (push && !full) begin
        if (decode_utf8_byte(item, predicted)) expected_q.push_back(predicted);
      end
    end
    outstanding <= expected_q.size();
    fail_count  <= fails;
    points_seen <= points;
    ends_seen   <= ends;
  end

endmodule

FILE: bench/utf8_to_code_point_decoder_test.sv
`timescale 1ns / 100ps
// utf8_to_code_point_decoder_test: drives byte streams into the decoder with
// bursty pushes and stalling pops, and gives the verdict
// depends on utf8d_pkg, the decoder rtl and utf8_to_code_point_decoder_check

module utf8_to_code_point_decoder_test;
  import utf8d_pkg::*;

  localparam int  N_BYTES = 2000;
  localparam longint LIMIT = 400000;

  logic     clk  = 1'b0;
  logic     rst  = 1'b1;
  logic     push = 1'b0;
  logic     pop  = 1'b0;
  in_item_t item = '0;
  logic     full;
  logic     empty;
  result_t  result;

  int     fail_count;
  int     outstanding;
  int     points_seen;
  int     ends_seen;
  int     sent       = 0;
  int     burst_left = 0;
  int     pop_mode   = 0;
  int     pop_left   = 0;
  longint cycles     = 0;

  always #1 clk = ~clk;

  utf8_to_code_point_decoder DUT (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .result (result),
    .empty  (empty),
    .pop    (pop)
  );

  utf8_to_code_point_decoder_check u_check (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .item        (item),
    .full        (full),
    .result      (result),
    .empty       (empty),
    .pop         (pop),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .points_seen (points_seen),
    .ends_seen   (ends_seen)
  );

  // receiver stall pattern
  always @(posedge clk) begin
    if (pop_left == 0) begin
      pop_mode = $urandom_range(0, 3);
      pop_left = $urandom_range(5, 60);
    end
    pop_left--;
    case (pop_mode)
      0: begin
        pop <= 1'b1;
      end
      1: begin
        pop <= 1'($urandom_range(0, 1));
      end
      2: begin
        pop <= ($urandom_range(0, 7) != 0);
      end
      default: begin
        pop <= ($urandom_range(0, 9) == 0);
      end
    endcase
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    push <= 1'b1;
    item <= {b, fin};
    do @(posedge clk); while (full);
    burst_left--;
    sent++;
  endtask

  // hold off until every expected result has come back
  task automatic drain();
    push <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic send_random_sequence();
    logic [7:0] seq_bytes [4];
    int         n;
    int         kind;
    kind = $urandom_range(0, 99);
    n    = 1;
    if (kind < 30) begin
      seq_bytes[0] = 8'($urandom_range(8'h00, 8'h7f));
    end else if (kind < 50) begin
      n = 2;
      seq_bytes[0] = 8'($urandom_range(LEAD2_LO, LEAD2_HI));
    end else if (kind < 70) begin
      n = 3;
      seq_bytes[0] = ($urandom_range(0, 3) == 0) ? LEAD3_LO
                                                  : 8'($urandom_range(LEAD3_LO, LEAD3_HI));
    end else if (kind < 85) begin
      n = 4;
      seq_bytes[0] = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
    end else begin
      seq_bytes[0] = 8'($urandom_range(0, 255));
    end
    for (int i = 1; i < n; i++) seq_bytes[i] = 8'($urandom_range(CONT_LO, CONT_HI));
    if (seq_bytes[0] == LEAD3_LO) seq_bytes[1] = 8'($urandom_range(STRICT_LO, CONT_HI));
    // broken sequences: a bad continuation or a cut-off tail
    if (n > 1 && $urandom_range(0, 9) == 0) begin
      seq_bytes[2'($urandom_range(1, n - 1))] = 8'($urandom_range(0, 255));
    end
    if (n > 1 && $urandom_range(0, 19) == 0) n = $urandom_range(1, n - 1);
    for (int i = 0; i < n; i++) send_byte(seq_bytes[i], $urandom_range(0, 49) == 0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // ascii extremes, ignored bytes, final on an ignored byte
    send_byte(8'h00, 1'b0); send_byte(8'h7f, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hc1, 1'b0); send_byte(8'hf5, 1'b0); send_byte(8'hff, 1'b1);
    // two, three and four byte extremes, surrogate and overlong forms
    send_byte(8'hc2, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hdf, 1'b0); send_byte(8'hbf, 1'b0);
    send_byte(8'he0, 1'b0); send_byte(8'ha0, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hef, 1'b0); send_byte(8'hbf, 1'b0); send_byte(8'hbf, 1'b0);
    send_byte(8'hed, 1'b0); send_byte(8'ha0, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hf0, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hf4, 1'b0); send_byte(8'hbf, 1'b0); send_byte(8'hbf, 1'b0);
    send_byte(8'hbf, 1'b0);
    // strict second byte after e0 violated, bad continuations
    send_byte(8'he0, 1'b0); send_byte(8'h9f, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hc2, 1'b0); send_byte(8'h41, 1'b0);
    send_byte(8'he1, 1'b0); send_byte(8'hc0, 1'b0); send_byte(8'h80, 1'b0);
    // unfinished sequence at the final byte, final on ascii and on completion
    send_byte(8'he2, 1'b0); send_byte(8'h82, 1'b1);
    send_byte(8'h41, 1'b1);
    send_byte(8'hc3, 1'b0); send_byte(8'ha9, 1'b1);
    drain();

    while (sent < N_BYTES) begin
      send_random_sequence();
      if ($urandom_range(0, 199) == 0) drain();
    end
    drain();
    repeat (8) @(posedge clk);

    $display("summary: %0d bytes pushed; %0d code points and %0d end marks checked",
             sent, points_seen, ends_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/utf8d_pkg.sv
rtl/utf8d_front.sv
rtl/utf8d_queue.sv
rtl/utf8d_back.sv
rtl/utf8_to_code_point_decoder.sv
bench/utf8_to_code_point_decoder_check.sv
bench/utf8_to_code_point_decoder_test.sv
